/* rtl/core/rmj_pkg.sv */
// Shared types and constants for the radar measurement Jacobian unit.
package rmj_pkg;

  localparam int QUOT_W  = 32;
  localparam int ROOT_W  = 32;
  localparam int DIV_LAT = QUOT_W + 1;
  localparam int PADDR_W = 3;

  localparam logic [PADDR_W-1:0] ADDR_MIN_SQ_RANGE = 3'd0;
  localparam logic [30:0]        MIN_SQ_RANGE_RST  = 31'd7;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
  } in_t;

  typedef struct packed {
    logic signed [31:0] range_dx;
    logic signed [31:0] range_dy;
    logic signed [31:0] bearing_dx;
    logic signed [31:0] bearing_dy;
    logic signed [31:0] rate_dx;
    logic signed [31:0] rate_dy;
    logic               near_zero;
  } out_t;

endpackage

/* rtl/core/rmj_div_pipe.sv */
// Pipelined restoring divider, one quotient bit per stage, with overflow flag.
module rmj_div_pipe #(
  parameter int NUM_W = 58,
  parameter int DEN_W = 33
) (
  input  logic                      clk,
  input  logic                      en,
  input  logic [NUM_W-1:0]          num,
  input  logic [DEN_W-1:0]          den,
  output logic [rmj_pkg::QUOT_W-1:0] quot,
  output logic                      ovf
);
  import rmj_pkg::*;

  localparam int HI_W  = NUM_W - QUOT_W;
  localparam int CMP_W = (HI_W > DEN_W) ? HI_W : DEN_W;

  logic [DEN_W-1:0]  rem_r [0:QUOT_W-1];
  logic [QUOT_W-1:0] low_r [0:QUOT_W-1];
  logic [DEN_W-1:0]  den_r [0:QUOT_W-1];
  logic [QUOT_W-1:0] q_r   [0:QUOT_W];
  logic [QUOT_W:0]   ovf_r;

  logic [CMP_W-1:0] hi_ext;
  logic [CMP_W-1:0] den_ext;

  assign hi_ext  = CMP_W'(num[NUM_W-1:QUOT_W]);
  assign den_ext = CMP_W'(den);

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= hi_ext[DEN_W-1:0];
      low_r[0] <= num[QUOT_W-1:0];
      den_r[0] <= den;
      q_r[0]   <= '0;
      ovf_r[0] <= (hi_ext >= den_ext);
    end
  end

  for (genvar k = 1; k <= QUOT_W; k++) begin : g_stage
    logic [DEN_W:0] sh;
    logic [DEN_W:0] df;
    logic           ge;

    assign sh = {rem_r[k-1], low_r[k-1][QUOT_W-1]};
    assign ge = (sh >= {1'b0, den_r[k-1]});
    assign df = sh - {1'b0, den_r[k-1]};

    always_ff @(posedge clk) begin
      if (en) begin
        q_r[k]   <= {q_r[k-1][QUOT_W-2:0], ge};
        ovf_r[k] <= ovf_r[k-1];
      end
    end

    if (k < QUOT_W) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[k] <= ge ? df[DEN_W-1:0] : sh[DEN_W-1:0];
          low_r[k] <= {low_r[k-1][QUOT_W-2:0], 1'b0};
          den_r[k] <= den_r[k-1];
        end
      end
    end
  end

  assign quot = q_r[QUOT_W];
  assign ovf  = ovf_r[QUOT_W];

endmodule

/* rtl/core/radar_measurement_jacobian_unit.sv */
// Radar measurement Jacobian unit: top level with square root and divider pipeline.
// Throughput: one beat per cycle while in_stall is low; the depth is set by the 32-stage
// square root and the 33-stage dividers that follow it.
// Reset: synchronous on rst_n low; the pipeline empties and min_squared_range returns to 7.
module radar_measurement_jacobian_unit #(
  parameter int FRAC_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  rmj_pkg::in_t                        in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output rmj_pkg::out_t                       out_data,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [rmj_pkg::PADDR_W-1:0]         paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready
);
  import rmj_pkg::*;

  localparam int F     = FRAC_BITS;
  localparam int NR_W  = 34 + F;
  localparam int DR_W  = 33;
  localparam int NB_W  = (((33 + 2 * F) > 64) ? (33 + 2 * F) : 64) + 1;
  localparam int DB_W  = 65;
  localparam int NQ_W  = 98 + F;
  localparam int DQ_W  = 97;
  localparam int SQ_N  = ROOT_W;
  localparam int NSTG  = 2 + SQ_N + 3 + DIV_LAT;
  localparam int RANGE_ONE = 1 << F;

  typedef struct packed {
    logic [31:0] am;
    logic [31:0] bm;
    logic        sa;
    logic        sb;
    logic [63:0] s;
    logic [63:0] dmag;
    logic        negx;
    logic        negy;
    logic        nz;
  } pay_t;

  typedef struct packed {
    pay_t        pay;
    logic [33:0] rem;
    logic [31:0] root;
    logic [63:0] rad;
  } sq_t;

  typedef struct packed {
    pay_t        pay;
    logic [31:0] r;
    logic [63:0] sl;
    logic [63:0] sh;
    logic [63:0] xl;
    logic [63:0] xh;
    logic [63:0] yl;
    logic [63:0] yh;
  } m1_t;

  typedef struct packed {
    pay_t        pay;
    logic [31:0] r;
    logic [95:0] cube;
    logic [95:0] px;
    logic [95:0] py;
  } m2_t;

  typedef struct packed {
    logic [5:0] neg;
    logic       nz;
  } side_t;

  function automatic sq_t sq_step(sq_t x);
    sq_t         y;
    logic [35:0] sh;
    logic [35:0] tr;
    y  = x;
    sh = {x.rem, x.rad[63:62]};
    tr = {2'b00, x.root, 2'b01};
    if (sh >= tr) begin
      y.rem  = 34'(sh - tr);
      y.root = {x.root[30:0], 1'b1};
    end else begin
      y.rem  = sh[33:0];
      y.root = {x.root[30:0], 1'b0};
    end
    y.rad = {x.rad[61:0], 2'b00};
    return y;
  endfunction

  function automatic logic [31:0] sat_q(logic [31:0] q, logic ov, logic neg);
    logic [31:0] lim;
    logic [31:0] mag;
    lim = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
    mag = (ov || (q > lim)) ? lim : q;
    return neg ? (32'd0 - mag) : mag;
  endfunction

  logic [NSTG-1:0] vld_r;
  logic            out_valid_r;
  out_t            out_data_r;
  out_t            out_nxt;
  logic [30:0]     msr_r;
  logic            out_take;
  logic            adv;

  assign out_take = !out_valid_r || !out_stall;
  assign adv      = out_take || !vld_r[NSTG-1];
  assign in_stall = !adv;

  // Stage 1: magnitudes and the four 32x32 products.
  logic [31:0]        p1_am_r, p1_bm_r;
  logic               p1_sa_r, p1_sb_r;
  logic [63:0]        p1_sqa_r, p1_sqb_r;
  logic signed [63:0] p1_cb_r, p1_da_r;
  logic [31:0]        am_nxt, bm_nxt;

  assign am_nxt = in_data.pos_x[31] ? (32'd0 - in_data.pos_x) : in_data.pos_x;
  assign bm_nxt = in_data.pos_y[31] ? (32'd0 - in_data.pos_y) : in_data.pos_y;

  always_ff @(posedge clk) begin
    if (adv) begin
      p1_am_r  <= am_nxt;
      p1_bm_r  <= bm_nxt;
      p1_sa_r  <= in_data.pos_x[31];
      p1_sb_r  <= in_data.pos_y[31];
      p1_sqa_r <= 64'(am_nxt) * 64'(am_nxt);
      p1_sqb_r <= 64'(bm_nxt) * 64'(bm_nxt);
      p1_cb_r  <= 64'(in_data.vel_x) * 64'(in_data.pos_y);
      p1_da_r  <= 64'(in_data.vel_y) * 64'(in_data.pos_x);
    end
  end

  // Stage 2: squared range, threshold test and cross-term difference.
  pay_t               p2_r;
  pay_t               p2_nxt;
  logic signed [64:0] dx;
  logic [63:0]        thr;

  assign dx  = 65'(p1_cb_r) - 65'(p1_da_r);
  assign thr = 64'(msr_r) << F;

  always_comb begin
    p2_nxt.am   = p1_am_r;
    p2_nxt.bm   = p1_bm_r;
    p2_nxt.sa   = p1_sa_r;
    p2_nxt.sb   = p1_sb_r;
    p2_nxt.s    = p1_sqa_r + p1_sqb_r;
    p2_nxt.dmag = dx[64] ? 64'(65'd0 - dx) : dx[63:0];
    p2_nxt.negx = dx[64] ^ p1_sb_r;
    p2_nxt.negy = (!dx[64] && (dx != '0)) ^ p1_sa_r;
    p2_nxt.nz   = (p2_nxt.s == '0) || (p2_nxt.s < thr);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p2_r <= p2_nxt;
    end
  end

  // Square root, one result bit per stage.
  sq_t sq_r [0:SQ_N-1];
  sq_t sq_in;

  assign sq_in = '{pay: p2_r, rem: '0, root: '0, rad: p2_r.s};

  always_ff @(posedge clk) begin
    if (adv) begin
      sq_r[0] <= sq_step(sq_in);
      for (int k = 1; k < SQ_N; k++) begin
        sq_r[k] <= sq_step(sq_r[k-1]);
      end
    end
  end

  // Partial products of S*R and of the cross-term difference.
  m1_t m1_r;
  m2_t m2_r;
  sq_t sq_o;

  assign sq_o = sq_r[SQ_N-1];

  always_ff @(posedge clk) begin
    if (adv) begin
      m1_r.pay <= sq_o.pay;
      m1_r.r   <= sq_o.root;
      m1_r.sl  <= 64'(sq_o.pay.s[31:0]) * 64'(sq_o.root);
      m1_r.sh  <= 64'(sq_o.pay.s[63:32]) * 64'(sq_o.root);
      m1_r.xl  <= 64'(sq_o.pay.dmag[31:0]) * 64'(sq_o.pay.bm);
      m1_r.xh  <= 64'(sq_o.pay.dmag[63:32]) * 64'(sq_o.pay.bm);
      m1_r.yl  <= 64'(sq_o.pay.dmag[31:0]) * 64'(sq_o.pay.am);
      m1_r.yh  <= 64'(sq_o.pay.dmag[63:32]) * 64'(sq_o.pay.am);
      m2_r.pay  <= m1_r.pay;
      m2_r.r    <= m1_r.r;
      m2_r.cube <= {m1_r.sh, 32'd0} + 96'(m1_r.sl);
      m2_r.px   <= {m1_r.xh, 32'd0} + 96'(m1_r.xl);
      m2_r.py   <= {m1_r.yh, 32'd0} + 96'(m1_r.yl);
    end
  end

  // Rounded dividends and doubled divisors.
  logic [NR_W-1:0] n_rx_r, n_ry_r;
  logic [DR_W-1:0] d_r_r;
  logic [NB_W-1:0] n_bx_r, n_by_r;
  logic [DB_W-1:0] d_b_r;
  logic [NQ_W-1:0] n_qx_r, n_qy_r;
  logic [DQ_W-1:0] d_q_r;
  side_t           m3_side_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      n_rx_r <= (NR_W'(m2_r.pay.am) << (F + 1)) + NR_W'(m2_r.r);
      n_ry_r <= (NR_W'(m2_r.pay.bm) << (F + 1)) + NR_W'(m2_r.r);
      d_r_r  <= {m2_r.r, 1'b0};
      n_bx_r <= (NB_W'(m2_r.pay.bm) << (2 * F + 1)) + NB_W'(m2_r.pay.s);
      n_by_r <= (NB_W'(m2_r.pay.am) << (2 * F + 1)) + NB_W'(m2_r.pay.s);
      d_b_r  <= {m2_r.pay.s, 1'b0};
      n_qx_r <= (NQ_W'(m2_r.px) << (F + 1)) + NQ_W'(m2_r.cube);
      n_qy_r <= (NQ_W'(m2_r.py) << (F + 1)) + NQ_W'(m2_r.cube);
      d_q_r  <= {m2_r.cube, 1'b0};
      m3_side_r.neg <= {m2_r.pay.sa, m2_r.pay.sb, !m2_r.pay.sb, m2_r.pay.sa,
                        m2_r.pay.negx, m2_r.pay.negy};
      m3_side_r.nz  <= m2_r.pay.nz;
    end
  end

  logic [QUOT_W-1:0] q_rx, q_ry, q_bx, q_by, q_qx, q_qy;
  logic              o_rx, o_ry, o_bx, o_by, o_qx, o_qy;

  rmj_div_pipe #(.NUM_W(NR_W), .DEN_W(DR_W)) u_div_rx (
    .clk(clk), .en(adv), .num(n_rx_r), .den(d_r_r), .quot(q_rx), .ovf(o_rx));
  rmj_div_pipe #(.NUM_W(NR_W), .DEN_W(DR_W)) u_div_ry (
    .clk(clk), .en(adv), .num(n_ry_r), .den(d_r_r), .quot(q_ry), .ovf(o_ry));
  rmj_div_pipe #(.NUM_W(NB_W), .DEN_W(DB_W)) u_div_bx (
    .clk(clk), .en(adv), .num(n_bx_r), .den(d_b_r), .quot(q_bx), .ovf(o_bx));
  rmj_div_pipe #(.NUM_W(NB_W), .DEN_W(DB_W)) u_div_by (
    .clk(clk), .en(adv), .num(n_by_r), .den(d_b_r), .quot(q_by), .ovf(o_by));
  rmj_div_pipe #(.NUM_W(NQ_W), .DEN_W(DQ_W)) u_div_qx (
    .clk(clk), .en(adv), .num(n_qx_r), .den(d_q_r), .quot(q_qx), .ovf(o_qx));
  rmj_div_pipe #(.NUM_W(NQ_W), .DEN_W(DQ_W)) u_div_qy (
    .clk(clk), .en(adv), .num(n_qy_r), .den(d_q_r), .quot(q_qy), .ovf(o_qy));

  side_t sd_r [0:DIV_LAT-1];

  always_ff @(posedge clk) begin
    if (adv) begin
      sd_r[0] <= m3_side_r;
      for (int k = 1; k < DIV_LAT; k++) begin
        sd_r[k] <= sd_r[k-1];
      end
    end
  end

  always_comb begin
    if (sd_r[DIV_LAT-1].nz) begin
      out_nxt           = '0;
      out_nxt.near_zero = 1'b1;
    end else begin
      out_nxt.range_dx   = sat_q(q_rx, o_rx, sd_r[DIV_LAT-1].neg[5]);
      out_nxt.range_dy   = sat_q(q_ry, o_ry, sd_r[DIV_LAT-1].neg[4]);
      out_nxt.bearing_dx = sat_q(q_bx, o_bx, sd_r[DIV_LAT-1].neg[3]);
      out_nxt.bearing_dy = sat_q(q_by, o_by, sd_r[DIV_LAT-1].neg[2]);
      out_nxt.rate_dx    = sat_q(q_qx, o_qx, sd_r[DIV_LAT-1].neg[1]);
      out_nxt.rate_dy    = sat_q(q_qy, o_qy, sd_r[DIV_LAT-1].neg[0]);
      out_nxt.near_zero  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_take) begin
      out_data_r <= out_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
      msr_r       <= MIN_SQ_RANGE_RST;
    end else begin
      if (adv) begin
        vld_r <= {vld_r[NSTG-2:0], in_valid};
      end
      if (out_take) begin
        out_valid_r <= vld_r[NSTG-1];
      end
      if (psel && penable && pwrite && (paddr == ADDR_MIN_SQ_RANGE)) begin
        msr_r <= pwdata[30:0];
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign pready    = 1'b1;
  assign prdata    = (paddr == ADDR_MIN_SQ_RANGE) ? {1'b0, msr_r} : 32'd0;

`ifndef SYNTH
  a_accept_enters : assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> vld_r[0])
    else $error("accepted beat did not enter the pipeline");

  a_tail_holds : assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[NSTG-1] && out_valid && out_stall) |-> in_stall)
    else $error("pipeline advanced over a held result");

  a_near_zero_clear : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.near_zero) |->
      (out_data.range_dx == 0) && (out_data.range_dy == 0) &&
      (out_data.bearing_dx == 0) && (out_data.bearing_dy == 0) &&
      (out_data.rate_dx == 0) && (out_data.rate_dy == 0))
    else $error("near-zero beat carries nonzero partials");

  a_range_bound : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.near_zero) |->
      (out_data.range_dx <= RANGE_ONE) && (out_data.range_dx >= -RANGE_ONE))
    else $error("range partial exceeds one");
`endif

endmodule

/* test/tb_radar_measurement_jacobian_unit.sv */
// Self-checking testbench for the radar measurement Jacobian unit.
`timescale 1ns / 100ps

module tb_radar_measurement_jacobian_unit;
  import rmj_pkg::*;

  localparam int FRAC = 16;
  localparam int DRAIN_CYCLES = 100;

  typedef logic [131:0] wide_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  logic [30:0] min_sq_range = MIN_SQ_RANGE_RST;
  out_t jacobians_due[$];
  int stall_pct = 0;
  int hold_cycles = 0;
  bit failed = 1'b0;

  radar_measurement_jacobian_unit #(.FRAC_BITS(FRAC)) DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic logic [63:0] int_sqrt(logic [63:0] v);
    logic [63:0] res;
    logic [63:0] bitv;
    res = '0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // Quotient rounded to nearest with ties away from zero, then clamped.
  function automatic logic [31:0] round_sat(wide_t num, wide_t den, bit neg);
    wide_t q;
    wide_t lim;
    q = ((num << 1) + den) / (den << 1);
    lim = neg ? wide_t'(64'h8000_0000) : wide_t'(64'h7FFF_FFFF);
    if (q > lim) q = lim;
    return neg ? 32'(-q[31:0]) : q[31:0];
  endfunction

  function automatic logic [63:0] magnitude(logic signed [63:0] v);
    return v < 0 ? 64'(-v) : 64'(v);
  endfunction

  function automatic logic [31:0] rate_partial(logic signed [63:0] q, logic signed [63:0] p1,
                                               logic signed [63:0] p2, wide_t den);
    logic [63:0] diff;
    bit neg;
    if (p1 >= p2) begin
      diff = 64'(p1 - p2);
      neg = 1'b0;
    end else begin
      diff = 64'(p2 - p1);
      neg = 1'b1;
    end
    if (q < 0) neg = !neg;
    return round_sat((wide_t'(diff) * wide_t'(magnitude(q))) << FRAC, den, neg);
  endfunction

  function automatic out_t jacobian(in_t st);
    logic signed [63:0] a, b, c, d;
    logic [63:0] am, bm, s, thr, r;
    out_t o;
    o = '0;
    a = st.pos_x;
    b = st.pos_y;
    c = st.vel_x;
    d = st.vel_y;
    am = magnitude(a);
    bm = magnitude(b);
    s = am * am + bm * bm;
    thr = 64'(min_sq_range) << FRAC;
    if (s == 0 || s < thr) begin
      o.near_zero = 1'b1;
      return o;
    end
    r = int_sqrt(s);
    o.range_dx = round_sat(wide_t'(am) << FRAC, wide_t'(r), a < 0);
    o.range_dy = round_sat(wide_t'(bm) << FRAC, wide_t'(r), b < 0);
    o.bearing_dx = round_sat(wide_t'(bm) << (2 * FRAC), wide_t'(s), !(b < 0));
    o.bearing_dy = round_sat(wide_t'(am) << (2 * FRAC), wide_t'(s), a < 0);
    o.rate_dx = rate_partial(b, c * b, d * a, wide_t'(s) * wide_t'(r));
    o.rate_dy = rate_partial(a, a * d, b * c, wide_t'(s) * wide_t'(r));
    return o;
  endfunction

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t %s expected %h actual %h", $time, name, exp_v, act_v);
      failed = 1'b1;
    end
  endtask

  always @(posedge clk) begin
    out_t exp_o;
    if (rst_n && out_valid && !out_stall) begin
      if (jacobians_due.size() == 0) begin
        $display("%0t unexpected beat expected none actual %h", $time, out_data);
        failed = 1'b1;
      end else begin
        exp_o = jacobians_due.pop_front();
        check_field("range_dx", exp_o.range_dx, out_data.range_dx);
        check_field("range_dy", exp_o.range_dy, out_data.range_dy);
        check_field("bearing_dx", exp_o.bearing_dx, out_data.bearing_dx);
        check_field("bearing_dy", exp_o.bearing_dy, out_data.bearing_dy);
        check_field("rate_dx", exp_o.rate_dx, out_data.rate_dx);
        check_field("rate_dy", exp_o.rate_dy, out_data.rate_dy);
        check_field("near_zero", 32'(exp_o.near_zero), 32'(out_data.near_zero));
      end
    end
  end

  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      out_stall <= 1'b1;
      hold_cycles = hold_cycles - 1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  task automatic send_state(in_t st);
    in_valid <= 1'b1;
    in_data <= st;
    do @(posedge clk); while (in_stall);
    jacobians_due.push_back(jacobian(st));
  endtask

  task automatic pause_sender(int n);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic send_vec(int px, int py, int vx, int vy);
    in_t st;
    st.pos_x = px;
    st.pos_y = py;
    st.vel_x = vx;
    st.vel_y = vy;
    send_state(st);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (jacobians_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_threshold(logic [30:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_MIN_SQ_RANGE;
    pwdata <= {1'b0, value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    min_sq_range = value;
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[30:0] !== value) begin
      $display("%0t threshold readback expected %h actual %h", $time, value, prdata);
      failed = 1'b1;
    end
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [31:0] rand_field();
    logic [31:0] v;
    v = $urandom();
    if ($urandom_range(0, 3) != 0) v = 32'($signed(v) >>> $urandom_range(0, 31));
    return v;
  endfunction

  task automatic test_directed();
    stall_pct = 0;
    send_vec(0, 0, 0, 0);
    send_vec(1, 0, 0, 0);
    send_vec(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_vec(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_vec(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
    send_vec(32'h7FFF_FFFF, 0, 32'h8000_0000, 32'h7FFF_FFFF);
    send_vec(0, 32'h8000_0000, 32'hFFFF_FFFF, 1);
    send_vec(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'hFFFF_0000);
    send_vec(32'hFFFD_0000, 32'h0004_0000, 32'h0002_0000, 32'h0003_0000);
    send_vec(2, 2, 32'h7FFF_FFFF, 32'h8000_0000);
    send_vec(3, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_vec(0, -3, 32'h8000_0000, 32'h7FFF_FFFF);
    send_vec(32'h0000_0300, 0, 0, 0);
    send_vec(32'h0000_02A5, 32'h0000_0001, 5, -5);
    send_vec(32'h0000_02A6, 32'hFFFF_FFFF, -5, 5);
    send_vec(-1, -1, -1, -1);
    send_vec(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA);
    send_vec(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555);
    wait_idle();
  endtask

  task automatic test_threshold_extremes();
    write_threshold('0);
    send_vec(0, 0, 1, 1);
    send_vec(1, 0, 1, 1);
    send_vec(0, -1, 32'h8000_0000, 32'h7FFF_FFFF);
    wait_idle();
    write_threshold(31'h7FFF_FFFF);
    send_vec(32'h7FFF_FFFF, 32'h7FFF_FFFF, 5, 7);
    send_vec(32'h00B5_04F3, 32'h00B5_04F3, 5, 7);
    send_vec(32'h0100_0000, 0, 5, 7);
    send_vec(32'h7FFF_0000, 0, 32'h8000_0000, 32'h7FFF_FFFF);
    wait_idle();
  endtask

  task automatic random_burst_phase(int count);
    int sent;
    int burst;
    in_t st;
    sent = 0;
    while (sent < count) begin
      stall_pct = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(5, 70);
      burst = $urandom_range(1, 24);
      repeat (burst) begin
        st.pos_x = rand_field();
        st.pos_y = rand_field();
        st.vel_x = rand_field();
        st.vel_y = rand_field();
        send_state(st);
        sent++;
      end
      pause_sender($urandom_range(0, 6));
    end
    wait_idle();
  endtask

  task automatic test_random();
    write_threshold(MIN_SQ_RANGE_RST);
    random_burst_phase(250);
    write_threshold('0);
    random_burst_phase(200);
    write_threshold(31'($urandom_range(1, 32'hFFFF)));
    random_burst_phase(200);
    write_threshold(31'h7FFF_FFFF);
    random_burst_phase(100);
  endtask

  task automatic test_backpressure();
    write_threshold(31'd7);
    stall_pct = 0;
    hold_cycles = 400;
    repeat (150) send_vec(rand_field(), rand_field(), rand_field(), rand_field());
    wait_idle();
  endtask

  initial begin
    #6_000_000;
    $display("FAIL radar_measurement_jacobian_unit");
    $finish;
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_threshold_extremes();
    test_backpressure();
    test_random();
    if (!failed) begin
      $display("PASS radar_measurement_jacobian_unit");
    end else begin
      $display("FAIL radar_measurement_jacobian_unit");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/core/rmj_pkg.sv
rtl/core/rmj_div_pipe.sv
rtl/core/radar_measurement_jacobian_unit.sv
test/tb_radar_measurement_jacobian_unit.sv
